>>> rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder core.
// ----------------------------------------------------------------------------
package u2u_pkg;

  // Input transaction: one byte of UTF-8 text
  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_end;
  } in_t;

  // Output transaction: one UTF-16 code unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } out_t;

  // Kind of multi-byte sequence in progress
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2,
    KIND_FOUR  = 2'd3
  } seq_kind_t;

  // Completed sequence handed from front to back
  typedef struct packed {
    logic [20:0] value;
    logic        pair;
  } qent_t;

  // Front status, visible to the top level
  typedef struct packed {
    seq_kind_t  kind;
    logic [1:0] pending;
  } front_stat_t;

  // Back status, visible to the top level
  typedef struct packed {
    logic trail_pending;
  } back_stat_t;

  // Lead byte classes
  localparam logic [7:0] LEAD_TWO_MIN   = 8'h80;
  localparam logic [7:0] LEAD_THREE_MIN = 8'h80 + 8'h40 + 8'h20;
  localparam logic [7:0] LEAD_FOUR_MIN  = 8'hF0;

  // Payload masks
  localparam logic [7:0] MASK_CONT_WIDE = 8'h7F;
  localparam logic [7:0] MASK_CONT_FOUR = 8'h3F;
  localparam logic [7:0] MASK_LEAD_TWO  = 8'h1F;
  localparam logic [7:0] MASK_LEAD_THR  = 8'h0F;
  localparam logic [7:0] MASK_LEAD_FOUR = 8'h07;

  // Surrogate constants
  localparam logic [21:0] SUR_OFFSET     = 22'h010000;
  localparam logic [15:0] SUR_LEAD_BASE  = 16'hD800;
  localparam logic [15:0] SUR_TRAIL_BASE = 16'hDC00;

  // Default depth of the front-to-back queue
  localparam int unsigned Q_DEPTH = 2;

endpackage

>>> rtl/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// Accepts UTF-8 bytes, tracks the sequence in progress and pushes each
// completed sequence value into the queue.
// ----------------------------------------------------------------------------
module u2u_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  u2u_pkg::in_t       byte_in,
  output logic               push,
  output u2u_pkg::qent_t     push_ent,
  output u2u_pkg::front_stat_t stat
);
  import u2u_pkg::*;

  seq_kind_t   kind, kind_next;
  logic [1:0]  pending, pending_next;
  logic [20:0] acc, acc_next;

  logic [7:0]  b;
  logic [7:0]  cont_bits;
  logic [20:0] acc_sum;
  logic [1:0]  pend_dec;

  assign b        = byte_in.text_byte;
  assign pend_dec = pending - 2'd1;

  // Continuation payload: six bits in four-byte sequences, seven otherwise
  always_comb begin
    unique case (kind)
      KIND_FOUR: cont_bits = b & MASK_CONT_FOUR;
      default:   cont_bits = b & MASK_CONT_WIDE;
    endcase
  end

  assign acc_sum = {acc[14:0], 6'b0} + {13'b0, cont_bits};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      kind    <= KIND_IDLE;
      pending <= 2'd0;
      acc     <= '0;
    end else begin
      kind    <= kind_next;
      pending <= pending_next;
      acc     <= acc_next;
    end
  end

  // Next state and queue push
  always_comb begin
    kind_next    = kind;
    pending_next = pending;
    acc_next     = acc;
    push         = 1'b0;
    push_ent     = '0;
    if (accept) begin
      if (pending == 2'd0) begin
        // Lead byte
        priority if (b < LEAD_TWO_MIN) begin
          push           = 1'b1;
          push_ent.value = {13'b0, b};
          push_ent.pair  = 1'b0;
          kind_next      = KIND_IDLE;
          pending_next   = 2'd0;
          acc_next       = '0;
        end else if (b < LEAD_THREE_MIN) begin
          kind_next    = KIND_TWO;
          pending_next = 2'd1;
          acc_next     = {13'b0, b & MASK_LEAD_TWO};
        end else if (b < LEAD_FOUR_MIN) begin
          kind_next    = KIND_THREE;
          pending_next = 2'd2;
          acc_next     = {13'b0, b & MASK_LEAD_THR};
        end else begin
          kind_next    = KIND_FOUR;
          pending_next = 2'd3;
          acc_next     = {13'b0, b & MASK_LEAD_FOUR};
        end
        if (byte_in.string_end) begin
          kind_next    = KIND_IDLE;
          pending_next = 2'd0;
          acc_next     = '0;
        end
      end else if (pend_dec != 2'd0) begin
        // Continuation, more to come; string end drops the partial
        kind_next    = kind;
        pending_next = pend_dec;
        acc_next     = acc_sum;
        if (byte_in.string_end) begin
          kind_next    = KIND_IDLE;
          pending_next = 2'd0;
          acc_next     = '0;
        end
      end else begin
        // Final continuation: hand the value to the back
        push           = 1'b1;
        push_ent.value = acc_sum;
        push_ent.pair  = (kind == KIND_FOUR);
        kind_next      = KIND_IDLE;
        pending_next   = 2'd0;
        acc_next       = '0;
      end
    end
  end

  assign stat.kind    = kind;
  assign stat.pending = pending;

endmodule

>>> rtl/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue
// Short flop-based FIFO of completed sequences between front and back.
// ----------------------------------------------------------------------------
module u2u_queue #(
  parameter int unsigned DEPTH = u2u_pkg::Q_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  u2u_pkg::qent_t               push_ent,
  input  logic                         pop,
  output logic                         head_valid,
  output u2u_pkg::qent_t               head,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  import u2u_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  qent_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == LVL_W'(DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head       = mem[rd_ptr];
  assign level      = count;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_ent;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + LVL_W'(1);
        2'b01:   count <= count - LVL_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// Pops completed sequences and drives the output register, splitting
// four-byte values into a surrogate pair.
// ----------------------------------------------------------------------------
module u2u_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  u2u_pkg::qent_t      head,
  output logic                pop,
  output logic                unit_valid,
  input  logic                unit_stall,
  output u2u_pkg::out_t       unit_data,
  output u2u_pkg::back_stat_t stat
);
  import u2u_pkg::*;

  logic        trail_pending;
  logic [15:0] trail_unit;

  logic        load_ok;
  logic [21:0] diff;
  logic [25:0] diff_ext;
  logic [15:0] lead_sur;
  logic [15:0] trail_sur;

  // Surrogates: shift of (value - 0x10000) is arithmetic on the wrapped difference
  assign diff      = {1'b0, head.value} - SUR_OFFSET;
  assign diff_ext  = {{4{diff[21]}}, diff};
  assign lead_sur  = diff_ext[25:10] + SUR_LEAD_BASE;
  assign trail_sur = {6'b0, head.value[9:0]} + SUR_TRAIL_BASE;

  assign load_ok = !unit_valid || !unit_stall;
  assign pop     = load_ok && !trail_pending && head_valid;

  // Output register and trail holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid    <= 1'b0;
      trail_pending <= 1'b0;
    end else if (load_ok) begin
      if (trail_pending) begin
        unit_valid    <= 1'b1;
        trail_pending <= 1'b0;
      end else if (head_valid) begin
        unit_valid    <= 1'b1;
        trail_pending <= head.pair;
      end else begin
        unit_valid    <= 1'b0;
      end
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (trail_pending) begin
        unit_data.code_unit <= trail_unit;
        unit_data.run_last  <= 1'b1;
      end else if (head_valid) begin
        if (head.pair) begin
          unit_data.code_unit <= lead_sur;
          unit_data.run_last  <= 1'b0;
          trail_unit          <= trail_sur;
        end else begin
          unit_data.code_unit <= head.value[15:0];
          unit_data.run_last  <= 1'b1;
        end
      end
    end
  end

  assign stat.trail_pending = trail_pending;

endmodule

>>> rtl/utf8_to_utf16_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_core
// Streams UTF-8 bytes in and UTF-16 code units out.
//
//   channel  direction  handshake               payload
//   byte     in         byte_valid/byte_stall   in_t  {text_byte, string_end}
//   unit     out        unit_valid/unit_stall   out_t {code_unit, run_last}
//
// One byte is taken per clock while byte_stall is low; a completed sequence
// passes through the queue and then the output register of the back end. A
// surrogate pair leaves as lead then trail from the single output register.
// Reset (rst, synchronous) returns the decoder to idle and empties the queue.
// byte_stall rises only when the queue between front and back is full, so
// output stalls reach the input after QDEPTH held entries.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_core #(
  parameter int unsigned QDEPTH = u2u_pkg::Q_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  u2u_pkg::in_t  byte_data,
  output logic          unit_valid,
  input  logic          unit_stall,
  output u2u_pkg::out_t unit_data
);
  import u2u_pkg::*;

  localparam int unsigned LVL_W = $clog2(QDEPTH + 1);

  logic             accept;
  logic             push;
  qent_t            push_ent;
  logic             pop;
  logic             head_valid;
  qent_t            head;
  logic             full;
  logic [LVL_W-1:0] level;
  front_stat_t      fstat;
  back_stat_t       bstat;

  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  // Front: classify and gather
  u2u_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .byte_in  (byte_data),
    .push     (push),
    .push_ent (push_ent),
    .stat     (fstat)
  );

  // Queue between front and back
  u2u_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ent   (push_ent),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (full),
    .level      (level)
  );

  // Back: emit units
  u2u_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_data  (unit_data),
    .stat       (bstat)
  );

  // Queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(QDEPTH))
    else $error("queue level above depth");

  // String end always leaves the front idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && byte_data.string_end |=> fstat.kind == KIND_IDLE && fstat.pending == 2'd0)
    else $error("front not idle after string end");

  // A held trail surrogate implies a lead on the output
  a_trail_behind_lead: assert property (@(posedge clk) disable iff (rst)
    bstat.trail_pending |-> unit_valid && !unit_data.run_last)
    else $error("trail pending without lead on output");

  // A lead surrogate taken is followed by its trail
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !unit_stall && !unit_data.run_last |=> unit_valid && unit_data.run_last)
    else $error("lead surrogate not followed by trail");

endmodule
